### hdl/motc_pkg.sv
// Package: shared types, opcode tables and the per-entry mask and range functions for the opcode classifier.
package motc_pkg;

   localparam int unsigned EntryCount = 287;
   localparam int unsigned EntryWidth = 9;
   localparam int unsigned QueueDepth = 2;

   // One classified word handed from the front part to the back part.
   typedef struct packed {
      logic [EntryWidth-1:0] entry_number;
      logic                  known;
      logic [31:0]           word_address;
   } result_type;

   localparam logic [31:0] EntCode [EntryCount] = '{
      32'h00000000,
      32'h00000002, 32'h00200002,
      32'h00000006, 32'h00000046,
      32'h00000000, 32'h00000003, 32'h00000004, 32'h00000007, 32'h00000008,
      32'h00000009, 32'h0000000a, 32'h0000000b, 32'h0000000c, 32'h0000000d,
      32'h0000000f, 32'h00000010, 32'h00000011, 32'h00000012, 32'h00000013,
      32'h00000016, 32'h00000017, 32'h00000018, 32'h00000019, 32'h0000001a,
      32'h0000001b, 32'h0000001c, 32'h0000001d, 32'h00000020, 32'h00000021,
      32'h00000022, 32'h00000023, 32'h00000024, 32'h00000025, 32'h00000026,
      32'h00000027, 32'h0000002a, 32'h0000002b, 32'h0000002c, 32'h0000002d,
      32'h0000002e, 32'h0000002f, 32'h00000030, 32'h00000031, 32'h00000032,
      32'h00000033, 32'h00000034, 32'h00000036,
      32'h42000001, 32'h42000002, 32'h42000006, 32'h42000008,
      32'h42000018, 32'h42000019, 32'h4200001f, 32'h42000020,
      32'h40000000, 32'h40800000, 32'h41600000, 32'h41800000, 32'h41c00000,
      32'h45000000, 32'h45010000, 32'h45020000, 32'h45030000,
      32'h46000000, 32'h46000001, 32'h46000002, 32'h46000003, 32'h46000004,
      32'h46000005, 32'h46000006, 32'h46000007, 32'h4600000c, 32'h4600000d,
      32'h4600000e, 32'h4600000f, 32'h46000024, 32'h46000026, 32'h46000030,
      32'h46000031, 32'h46000032, 32'h46000033, 32'h46000034, 32'h46000036,
      32'h46000037, 32'h46000038, 32'h46000039, 32'h4600003a, 32'h4600003c,
      32'h4600003d, 32'h4600003e, 32'h4600003f,
      32'h46800020,
      32'h44000000, 32'h44400000, 32'h44800000, 32'h44c00000,
      32'h49000000, 32'h49010000, 32'h49020000, 32'h49030000,
      32'h48000000, 32'h48400000, 32'h48600000, 32'h48800000,
      32'h48c00000, 32'h48e00000,
      32'h60000000, 32'h60800000, 32'h61000000, 32'h63800000,
      32'h64000000, 32'h64800000, 32'h65000000, 32'h66000000,
      32'h66800000, 32'h67000000,
      32'h6c000000, 32'h6d000000, 32'h6d800000, 32'h6e800000,
      32'h6f000000, 32'h6f800000,
      32'h70000000, 32'h70000024, 32'h70000026,
      32'h7c0000a0, 32'h7c0000e0, 32'h7c000420, 32'h7c000520, 32'h7c000620,
      32'h7c000000, 32'h7c000004, 32'h7c00003b,
      32'hd0000000, 32'hd0010000, 32'hd0020000, 32'hd0030000, 32'hd0040000,
      32'hd0050000, 32'hd0060000, 32'hd0070000, 32'hd0100000, 32'hd0110000,
      32'hd0120000, 32'hd0130000, 32'hd0140000, 32'hd0150000, 32'hd0160000,
      32'hd0170000, 32'hd0180000, 32'hd01a0000, 32'hd01c0000,
      32'hd0200000, 32'hd0210000, 32'hd0220000, 32'hd0230000, 32'hd0320000,
      32'hd0330000, 32'hd0360000, 32'hd0370000, 32'hd0380000, 32'hd0390000,
      32'hd03a0000, 32'hd03b0000, 32'hd03c0000, 32'hd03d0000, 32'hd03e0000,
      32'hd03f0000,
      32'hd0400000, 32'hd0410000, 32'hd0420000, 32'hd0430000, 32'hd0440000,
      32'hd0450000, 32'hd0460000, 32'hd0470000, 32'hd0480000, 32'hd0490000,
      32'hd04a0000, 32'hd0500000, 32'hd0510000, 32'hd0590000, 32'hd05a0000,
      32'hd05b0000,
      32'hd3000000,
      32'hd0600000, 32'hd2000000, 32'hd2200000, 32'hd2400000, 32'hd2600000,
      32'hd2800000, 32'hd2a00000,
      32'hdc000000, 32'hdc800000, 32'hdd000000, 32'hdd800000, 32'hde000000,
      32'hde800000, 32'hdf000000, 32'hdf800000,
      32'hf3800000, 32'hf3830000, 32'hf3860000, 32'hf3870000,
      32'hf0000000, 32'hf0200000, 32'hf0400000, 32'hf0600000, 32'hf0800000,
      32'hf0a00000, 32'hf0c00000, 32'hf0e00000, 32'hf1000000, 32'hf1200000,
      32'hf1400000, 32'hf1600000, 32'hf1800000, 32'hf1a00000, 32'hf1c00000,
      32'hf1e00000, 32'hf2000000, 32'hf2200000, 32'hf2400000, 32'hf2600000,
      32'hf2800000, 32'hf3a00000,
      32'h08000000, 32'h0c000000, 32'h10000000, 32'h14000000, 32'h18000000,
      32'h1c000000, 32'h20000000, 32'h24000000, 32'h28000000, 32'h2c000000,
      32'h30000000, 32'h34000000, 32'h38000000, 32'h3c000000, 32'h50000000,
      32'h54000000, 32'h58000000, 32'h5c000000, 32'h80000000, 32'h84000000,
      32'h88000000, 32'h8c000000, 32'h90000000, 32'h94000000, 32'h98000000,
      32'ha0000000, 32'ha4000000, 32'ha8000000, 32'hac000000, 32'hb8000000,
      32'hbc000000, 32'hc0000000, 32'hc4000000, 32'hc8000000, 32'hd4000000,
      32'hd8000000, 32'he0000000, 32'he4000000, 32'he8000000, 32'hf4000000,
      32'hf8000000,
      32'h04000000, 32'h04010000, 32'h04020000, 32'h04030000, 32'h04080000,
      32'h04090000, 32'h040a0000, 32'h040b0000, 32'h040c0000, 32'h040e0000,
      32'h04100000, 32'h04110000, 32'h04120000, 32'h04130000, 32'h041f0000,
      32'hffff0000, 32'hffff0320, 32'hffff040d
   };

   // Per entry: mask, range low and range high of the group that owns it.
   function automatic logic [31:0] ent_mask(input int unsigned e);
      logic [31:0] m;
      if (e < 1)         m = 32'hffffffff;
      else if (e < 3)    m = 32'hffe0003f;
      else if (e < 5)    m = 32'hfc00007f;
      else if (e < 48)   m = 32'hfc00003f;
      else if (e < 56)   m = 32'hfe00003f;
      else if (e < 61)   m = 32'hffe00000;
      else if (e < 65)   m = 32'hffff0000;
      else if (e < 94)   m = 32'hffe0003f;
      else if (e < 98)   m = 32'hffe00000;
      else if (e < 102)  m = 32'hffe30000;
      else if (e < 108)  m = 32'hffe00000;
      else if (e < 124)  m = 32'hff800000;
      else if (e < 127)  m = 32'hfc00003f;
      else if (e < 132)  m = 32'hfc0007ff;
      else if (e < 135)  m = 32'hfc00003f;
      else if (e < 186)  m = 32'hffff0000;
      else if (e < 187)  m = 32'hff000000;
      else if (e < 194)  m = 32'hffe00000;
      else if (e < 202)  m = 32'hff800000;
      else if (e < 206)  m = 32'hffef0000;
      else if (e < 228)  m = 32'hffe00000;
      else if (e < 269)  m = 32'hfc000000;
      else if (e < 284)  m = 32'hfc1f0000;
      else               m = 32'hffff07ff;
      return m;
   endfunction

   function automatic logic [31:0] ent_lo(input int unsigned e);
      logic [31:0] v;
      if (e < 1)         v = 32'h00000000;
      else if (e < 3)    v = 32'h00000002;
      else if (e < 5)    v = 32'h00000006;
      else if (e < 48)   v = 32'h00000000;
      else if (e < 56)   v = 32'h42000000;
      else if (e < 61)   v = 32'h40000000;
      else if (e < 65)   v = 32'h45000000;
      else if (e < 93)   v = 32'h46000000;
      else if (e < 94)   v = 32'h46800000;
      else if (e < 98)   v = 32'h44000000;
      else if (e < 102)  v = 32'h49000000;
      else if (e < 108)  v = 32'h48000000;
      else if (e < 112)  v = 32'h60000000;
      else if (e < 118)  v = 32'h64000000;
      else if (e < 124)  v = 32'h6c000000;
      else if (e < 127)  v = 32'h70000000;
      else if (e < 132)  v = 32'h7c000020;
      else if (e < 135)  v = 32'h7c000000;
      else if (e < 154)  v = 32'hd0000000;
      else if (e < 170)  v = 32'hd0200000;
      else if (e < 186)  v = 32'hd0400000;
      else if (e < 187)  v = 32'hd3000000;
      else if (e < 194)  v = 32'hd0000000;
      else if (e < 202)  v = 32'hdc000000;
      else if (e < 206)  v = 32'hf3800000;
      else if (e < 228)  v = 32'hf0000000;
      else if (e < 269)  v = 32'h00000000;
      else if (e < 284)  v = 32'h04000000;
      else               v = 32'hffff0000;
      return v;
   endfunction

   function automatic logic [31:0] ent_hi(input int unsigned e);
      logic [31:0] v;
      if (e < 1)         v = 32'hffffffff;
      else if (e < 3)    v = 32'h00200002;
      else if (e < 5)    v = 32'h00000046;
      else if (e < 48)   v = 32'h0000003f;
      else if (e < 56)   v = 32'h4200003f;
      else if (e < 61)   v = 32'h43e00000;
      else if (e < 65)   v = 32'h451f0000;
      else if (e < 93)   v = 32'h4600003f;
      else if (e < 94)   v = 32'h4680003f;
      else if (e < 98)   v = 32'h47e00000;
      else if (e < 102)  v = 32'h49030000;
      else if (e < 108)  v = 32'h4be00000;
      else if (e < 112)  v = 32'h63800000;
      else if (e < 118)  v = 32'h67800000;
      else if (e < 124)  v = 32'h6f800000;
      else if (e < 127)  v = 32'h7000003f;
      else if (e < 132)  v = 32'h7c0007e0;
      else if (e < 135)  v = 32'h7c00003f;
      else if (e < 154)  v = 32'hd01f0000;
      else if (e < 170)  v = 32'hd03f0000;
      else if (e < 186)  v = 32'hd05f0000;
      else if (e < 187)  v = 32'hd3000000;
      else if (e < 194)  v = 32'hd3e00000;
      else if (e < 202)  v = 32'hdf800000;
      else if (e < 206)  v = 32'hf38f0000;
      else if (e < 228)  v = 32'hf3e00000;
      else if (e < 269)  v = 32'hfc000000;
      else if (e < 284)  v = 32'h041f0000;
      else               v = 32'hffff04ff;
      return v;
   endfunction

   // Depth-first search order as a flat list of entry runs (start, count).
   localparam int unsigned RunCount = 29;
   localparam int unsigned RunStart [RunCount] = '{
      0, 1, 3, 5, 48, 56, 61, 65, 93, 94, 98, 102, 108, 112, 118, 124,
      127, 132, 135, 154, 170, 186, 187, 194, 202, 206, 228, 269, 284
   };
   localparam int unsigned RunLen [RunCount] = '{
      1, 2, 2, 43, 8, 5, 4, 28, 1, 4, 4, 6, 4, 6, 6, 3,
      5, 3, 19, 16, 16, 1, 7, 8, 4, 22, 41, 15, 3
   };

endpackage

### hdl/motc_front.sv
// Front part: match the word against all entries and form its address.
module motc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               base_address,
   input  logic                      in_valid,
   input  logic [31:0]               instr_word,
   input  logic                      restart,
   input  logic                      queue_ready,
   output logic                      in_ready,
   output logic                      out_valid,
   output motc_pkg::result_type      out_data
);

   logic [motc_pkg::EntryCount-1:0] hit;
   logic [motc_pkg::EntryWidth-1:0] number;
   logic [31:0] offset_ff, offset_in, offset_used;
   logic        take;

   // Compare every entry in parallel against its group's masked word.
   always_comb begin
      logic [31:0] m;
      for (int unsigned e = 0; e < motc_pkg::EntryCount; e++) begin
         m = instr_word & motc_pkg::ent_mask(e);
         hit[e] = (m == motc_pkg::EntCode[e]) && (m >= motc_pkg::ent_lo(e))
                  && (m <= motc_pkg::ent_hi(e));
      end
   end

   // Pick the first hit in search order.
   always_comb begin
      logic found;
      found  = 1'b0;
      number = '0;
      for (int unsigned r = 0; r < motc_pkg::RunCount; r++) begin
         for (int unsigned k = 0; k < motc_pkg::RunLen[r]; k++) begin
            if (!found && hit[motc_pkg::RunStart[r] + k]) begin
               found  = 1'b1;
               number = motc_pkg::EntryWidth'(motc_pkg::RunStart[r] + k + 1);
            end
         end
      end
   end

   assign in_ready    = queue_ready;
   assign out_valid   = in_valid;
   assign take        = in_valid && queue_ready;
   assign offset_used = restart ? 32'd0 : offset_ff;
   assign offset_in   = take ? offset_used + 32'd4 : offset_ff;

   assign out_data.entry_number = number;
   assign out_data.known        = (number != '0);
   assign out_data.word_address = base_address + offset_used;

   // Advance the byte offset on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

### hdl/motc_queue.sv
// Back part: two-entry result queue driving the result channel.
module motc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  motc_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output motc_pkg::result_type out_data,
   input  logic                 out_ready
);

   motc_pkg::result_type slot_ff [motc_pkg::QueueDepth];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign rd_in     = pop ? ~rd_ff : rd_ff;
   assign wr_in     = push ? ~wr_ff : wr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   // Hold pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   // Store a pushed result.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("push lost");

endmodule

### hdl/mips_opcode_table_classifier_unit.sv
// Top level: opcode table classifier with address counter.
//
// Request channel (req_): one 32-bit instruction word per transfer, with
// tuser carrying the restart flag that marks the first word of a block.
// Response channel (rsp_): entry number (0 = unknown), known flag and the
// word's address (base plus running byte offset, 4 per word).
// csr_: write the base address while the block is idle.
// Each request transfer is registered in the result queue before its
// response is offered; one word per cycle is taken, set by the parallel
// table match in the front part. The two-entry queue separates the sides:
// a stalled receiver fills it, then req_tready drops until a slot frees.
// Reset clears the base address, byte offset and queue.
module mips_opcode_table_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [8:0] entry_number, [9] known,
                                    // [41:10] word_address, rest zero
);

   logic [31:0] base_ff;
   logic        f_valid, q_ready;
   motc_pkg::result_type f_data, q_data;

   // Hold the base address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   motc_front u_front (
      .clock(clock), .reset(reset), .base_address(base_ff),
      .in_valid(req_tvalid), .instr_word(req_tdata), .restart(req_tuser),
      .queue_ready(q_ready), .in_ready(req_tready),
      .out_valid(f_valid), .out_data(f_data)
   );

   motc_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_data(f_data),
      .in_ready(q_ready), .out_valid(rsp_tvalid), .out_data(q_data),
      .out_ready(rsp_tready)
   );

   assign rsp_tdata = {6'd0, q_data.word_address, q_data.known, q_data.entry_number};

endmodule
